>>> sv/rm2q_pkg.sv
// ----------------------------------------------------------------------------
// rm2q_pkg
// shared constants and types for the rotation matrix to quaternion core
// ----------------------------------------------------------------------------
package rm2q_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;

  // branch codes as reported in the result
  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X     = 2'd1;
  localparam logic [1:0] BR_Y     = 2'd2;
  localparam logic [1:0] BR_Z     = 2'd3;

  // classification of one request, carried from front to back
  typedef struct packed {
    logic [1:0] branch;
    logic       degen;
  } tag_t;

  localparam int TAG_W = 3;

endpackage

>>> sv/rm2q_front.sv
// ----------------------------------------------------------------------------
// rm2q_front
// picks the branch, forms the square-root argument and the three numerators
// ----------------------------------------------------------------------------
module rm2q_front #(
  parameter int DATA_WIDTH = rm2q_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rm2q_pkg::FRAC_BITS_DEF,
  parameter int AW         = DATA_WIDTH + 4
) (
  input  logic [9*DATA_WIDTH-1:0]     mat,
  output rm2q_pkg::tag_t              tag,
  output logic [AW-2:0]               arg,
  output logic [3*(DATA_WIDTH+1)-1:0] nums
);
  import rm2q_pkg::*;

  localparam int DW = DATA_WIDTH;

  logic signed [DW-1:0] m11, m12, m13, m21, m22, m23, m31, m32, m33;
  logic signed [AW-1:0] e11, e22, e33, one_v, trace, arg_s;
  logic signed [DW:0]   d_zy, d_xz, d_yx, s_xy, s_xz, s_yz;
  logic signed [DW:0]   n0, n1, n2;
  logic [1:0]           branch;

  assign m11 = mat[0*DW +: DW];
  assign m12 = mat[1*DW +: DW];
  assign m13 = mat[2*DW +: DW];
  assign m21 = mat[3*DW +: DW];
  assign m22 = mat[4*DW +: DW];
  assign m23 = mat[5*DW +: DW];
  assign m31 = mat[6*DW +: DW];
  assign m32 = mat[7*DW +: DW];
  assign m33 = mat[8*DW +: DW];

  assign e11   = AW'(m11);
  assign e22   = AW'(m22);
  assign e33   = AW'(m33);
  assign one_v = {{(AW-1-FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  assign trace = e11 + e22 + e33;

  assign d_zy = (DW+1)'(m32) - (DW+1)'(m23);
  assign d_xz = (DW+1)'(m13) - (DW+1)'(m31);
  assign d_yx = (DW+1)'(m21) - (DW+1)'(m12);
  assign s_xy = (DW+1)'(m12) + (DW+1)'(m21);
  assign s_xz = (DW+1)'(m13) + (DW+1)'(m31);
  assign s_yz = (DW+1)'(m23) + (DW+1)'(m32);

  // numerators come out in component order, skipping the scale component
  always_comb begin
    if (!trace[AW-1] && trace != '0) begin
      branch = BR_TRACE;
      arg_s  = one_v + trace;
      n0 = d_zy; n1 = d_xz; n2 = d_yx;
    end else if (e11 > e22 && e11 > e33) begin
      branch = BR_X;
      arg_s  = one_v + e11 - e22 - e33;
      n0 = d_zy; n1 = s_xy; n2 = s_xz;
    end else if (e22 > e33) begin
      branch = BR_Y;
      arg_s  = one_v + e22 - e11 - e33;
      n0 = d_xz; n1 = s_xy; n2 = s_yz;
    end else begin
      branch = BR_Z;
      arg_s  = one_v + e33 - e11 - e22;
      n0 = d_yx; n1 = s_xz; n2 = s_yz;
    end
  end

  assign tag.branch = branch;
  assign tag.degen  = arg_s[AW-1] || (arg_s == '0);
  assign arg        = arg_s[AW-2:0];
  assign nums       = {n2, n1, n0};

endmodule

>>> sv/rm2q_fifo.sv
// ----------------------------------------------------------------------------
// rm2q_fifo
// two-entry queue between the classifier and the arithmetic pipeline
// ----------------------------------------------------------------------------
module rm2q_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  import rm2q_pkg::*;

  logic [W-1:0] mem [2];
  logic         wptr, rptr;
  logic [1:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign dout  = mem[rptr];
  assign full  = count[1];
  assign empty = (count == 2'd0);

endmodule

>>> sv/rm2q_back.sv
// ----------------------------------------------------------------------------
// rm2q_back
// pipelined square root, three pipelined dividers and the output register
// ----------------------------------------------------------------------------
module rm2q_back #(
  parameter int DATA_WIDTH = rm2q_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rm2q_pkg::FRAC_BITS_DEF,
  parameter int AW         = DATA_WIDTH + 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  rm2q_pkg::tag_t              tag,
  input  logic [AW-2:0]               arg,
  input  logic [3*(DATA_WIDTH+1)-1:0] nums,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [4*DATA_WIDTH-1:0]     out_q,
  output rm2q_pkg::tag_t              out_tag
);
  import rm2q_pkg::*;

  localparam int DW  = DATA_WIDTH;
  localparam int RW0 = AW - 1 + FRAC_BITS + 2;
  localparam int RWE = RW0 + (RW0 % 2);
  localparam int RB  = RWE / 2;
  localparam int NW  = 3 * (DW + 1);
  localparam int SW  = TAG_W + NW;
  localparam int DVW = DW + 1 + FRAC_BITS;
  localparam int CW  = DVW + RB;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // square root, one result bit per stage
  logic            sv   [1:RB];
  logic [SW-1:0]   sside[1:RB];
  logic [RWE-1:0]  srad [1:RB];
  logic [RB+1:0]   srem [1:RB];
  logic [RB-1:0]   sroot[1:RB];

  for (genvar k = 0; k < RB; k++) begin : g_sq
    logic            v_i;
    logic [SW-1:0]   side_i;
    logic [RWE-1:0]  rad_i;
    logic [RB+1:0]   rem_i, rem_sh, cand;
    logic [RB-1:0]   root_i;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign side_i = {tag, nums};
      assign rad_i  = RWE'(arg) << (FRAC_BITS + 2);
      assign rem_i  = '0;
      assign root_i = '0;
    end else begin : g_rest
      assign v_i    = sv[k];
      assign side_i = sside[k];
      assign rad_i  = srad[k];
      assign rem_i  = srem[k];
      assign root_i = sroot[k];
    end

    assign rem_sh = {rem_i[RB-1:0], rad_i[RWE-1 -: 2]};
    assign cand   = {root_i, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (en) begin
        sv[k+1] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sside[k+1] <= side_i;
        srad[k+1]  <= rad_i << 2;
        if (rem_sh >= cand) begin
          srem[k+1]  <= rem_sh - cand;
          sroot[k+1] <= {root_i[RB-2:0], 1'b1};
        end else begin
          srem[k+1]  <= rem_sh;
          sroot[k+1] <= {root_i[RB-2:0], 1'b0};
        end
      end
    end
  end

  // dividers: an overflow check, then one quotient bit per stage
  logic            dv   [1:DW];
  logic [TAG_W-1:0] dtag[1:DW];
  logic [RB-1:0]   ds   [1:DW];
  logic [CW-1:0]   drem [1:DW][3];
  logic [DW-2:0]   dq   [1:DW][3];
  logic            dovf [1:DW][3];
  logic            dneg [1:DW][3];

  for (genvar j = 0; j < DW; j++) begin : g_dv
    logic             v_i;
    logic [TAG_W-1:0] tag_i;
    logic [RB-1:0]    s_i;

    if (j == 0) begin : g_first
      assign v_i   = sv[RB];
      assign tag_i = sside[RB][SW-1 -: TAG_W];
      assign s_i   = sroot[RB];
    end else begin : g_rest
      assign v_i   = dv[j];
      assign tag_i = dtag[j];
      assign s_i   = ds[j];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1] <= 1'b0;
      end else if (en) begin
        dv[j+1] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dtag[j+1] <= tag_i;
        ds[j+1]   <= s_i;
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      if (j == 0) begin : g_chk
        logic signed [DW:0] num;
        logic [DW:0]        mag;
        logic [CW-1:0]      dvd;
        assign num = sside[RB][l*(DW+1) +: DW+1];
        assign mag = num[DW] ? (DW+1)'(0) - num : num;
        assign dvd = CW'(mag) << FRAC_BITS;

        always_ff @(posedge clk) begin
          if (en) begin
            drem[1][l] <= dvd;
            dq[1][l]   <= '0;
            dovf[1][l] <= dvd >= (CW'(s_i) << (DW - 1));
            dneg[1][l] <= num[DW];
          end
        end
      end else begin : g_bit
        localparam int B = DW - 1 - j;
        logic [CW-1:0] trial;
        assign trial = CW'(s_i) << B;

        always_ff @(posedge clk) begin
          if (en) begin
            dovf[j+1][l] <= dovf[j][l];
            dneg[j+1][l] <= dneg[j][l];
            if (drem[j][l] >= trial) begin
              drem[j+1][l]  <= drem[j][l] - trial;
              dq[j+1][l]    <= dq[j][l] | ((DW-1)'(1) << B);
            end else begin
              drem[j+1][l]  <= drem[j][l];
              dq[j+1][l]    <= dq[j][l];
            end
          end
        end
      end
    end
  end

  // saturation and placement
  localparam logic signed [DW-1:0] HI = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] LO = {1'b1, {(DW-1){1'b0}}};

  tag_t                 ftag;
  logic [RB-1:0]        quarter;
  logic signed [DW-1:0] qs, qd [3];
  logic signed [DW-1:0] w, x, y, z;

  assign ftag    = dtag[DW];
  assign quarter = ds[DW] >> 2;
  assign qs      = (RB'(HI) < quarter) ? HI : DW'(quarter);

  for (genvar l = 0; l < 3; l++) begin : g_sat
    always_comb begin
      if (dovf[DW][l]) begin
        qd[l] = dneg[DW][l] ? LO : HI;
      end else if (dneg[DW][l]) begin
        qd[l] = DW'(0) - DW'(dq[DW][l]);
      end else begin
        qd[l] = DW'(dq[DW][l]);
      end
    end
  end

  always_comb begin
    case (ftag.branch)
      BR_TRACE: begin w = qs;    x = qd[0]; y = qd[1]; z = qd[2]; end
      BR_X:     begin w = qd[0]; x = qs;    y = qd[1]; z = qd[2]; end
      BR_Y:     begin w = qd[0]; x = qd[1]; y = qs;    z = qd[2]; end
      default:  begin w = qd[0]; x = qd[1]; y = qd[2]; z = qs;    end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tag <= ftag;
      out_q   <= ftag.degen ? '0 : {z, y, x, w};
    end
  end

endmodule

>>> sv/rotation_matrix_to_quaternion_core.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// converts a stream of 3x3 rotation matrices into quaternions
// ----------------------------------------------------------------------------
// Accepts one matrix per cycle while results are being taken and returns one
// quaternion per matrix, in order. A classifier picks the branch and feeds a
// two-entry queue; behind it a square root that resolves one bit per stage
// (ceil((DATA_WIDTH+FRAC_BITS+4)/2) stages when DATA_WIDTH exceeds FRAC_BITS+1,
// 17 at the defaults) is followed by three dividers that spend one stage on
// overflow and one per quotient bit (DATA_WIDTH stages), then the output
// register. The pipeline holds while a result waits to be taken. A degenerate
// matrix returns zeros with the degenerate flag set.
module rotation_matrix_to_quaternion_core #(
  parameter int DATA_WIDTH = rm2q_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rm2q_pkg::FRAC_BITS_DEF,
  parameter int IN_W       = ((9 * DATA_WIDTH + 7) / 8) * 8,
  parameter int OUT_W      = ((4 * DATA_WIDTH + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // m11 m12 m13 m21 m22 m23 m31 m32 m33
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // qw qx qy qz
  output logic [2:0]       m_tuser    // branch_taken[1:0] degenerate
);
  import rm2q_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int AW = ((DW > FRAC_BITS + 1) ? DW : FRAC_BITS + 1) + 3;
  localparam int NW = 3 * (DW + 1);
  localparam int FW = TAG_W + (AW - 1) + NW;

  tag_t            f_tag, b_tag, o_tag;
  logic [AW-2:0]   f_arg, b_arg;
  logic [NW-1:0]   f_nums, b_nums;
  logic            push, pop, full, empty, b_ready;
  logic [FW-1:0]   q_out;
  logic [4*DW-1:0] o_q;

  rm2q_front #(
    .DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .AW(AW)
  ) u_front (
    .mat (s_tdata[9*DW-1:0]),
    .tag (f_tag),
    .arg (f_arg),
    .nums(f_nums)
  );

  assign s_tready = !full;
  assign push     = s_tvalid && !full;
  assign pop      = !empty && b_ready;

  rm2q_fifo #(.W(FW)) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  ({f_tag, f_arg, f_nums}),
    .full (full),
    .pop  (pop),
    .dout (q_out),
    .empty(empty)
  );

  assign b_tag  = q_out[FW-1 -: TAG_W];
  assign b_arg  = q_out[NW +: AW-1];
  assign b_nums = q_out[NW-1:0];

  rm2q_back #(
    .DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .AW(AW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (!empty),
    .in_ready (b_ready),
    .tag      (b_tag),
    .arg      (b_arg),
    .nums     (b_nums),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_q    (o_q),
    .out_tag  (o_tag)
  );

  assign m_tdata = OUT_W'(o_q);
  assign m_tuser = {o_tag.degen, o_tag.branch};

  // a degenerate result carries all-zero components
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tdata[4*DW-1:0] == '0)
    else $error("degenerate result with nonzero components");

  // the trace branch always has a positive argument
  a_trace_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] == BR_TRACE |-> !m_tuser[2])
    else $error("trace branch flagged degenerate");

  // the scale component of the trace branch is never negative
  a_scale_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] == BR_TRACE |-> !m_tdata[DW-1])
    else $error("negative scale component");

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the rotation matrix to quaternion core: directed
// corner matrices, then random rotations and raw patterns, with random idle
// cycles on both stream sides, each result checked against a local predictor
// ----------------------------------------------------------------------------
module tb;
  import rm2q_pkg::*;

  localparam int DW = 16;
  localparam int FB = 14;
  localparam int ONE = 1 << FB;
  localparam int LIMIT = 400000;
  localparam int DRAIN = 80;

  typedef struct packed {
    logic [DW-1:0] qw, qx, qy, qz;
    logic [1:0]    branch;
    logic          degen;
  } quat_t;

  logic          clk = 0;
  logic          rst = 1;
  logic          s_tvalid = 0;
  logic          s_tready;
  logic [143:0]  s_tdata = '0;
  logic          m_tvalid;
  logic          m_tready = 0;
  logic [63:0]   m_tdata;
  logic [2:0]    m_tuser;

  quat_t quat_q[$];
  int    errors = 0;
  int    sent = 0;
  int    checked = 0;
  int    degen_seen = 0;
  int    branch_seen[4] = '{0, 0, 0, 0};
  int    cycles = 0;

  rotation_matrix_to_quaternion_core i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // floor(sqrt(a * 2^(FB+2))), digit by digit
  function automatic longint unsigned scale_root(longint unsigned a);
    logic [127:0] v;
    logic [127:0] root, rem, cand;
    v = 128'(a) << (FB + 2);
    root = 0;
    rem = 0;
    for (int p = 35; p >= 0; p--) begin
      rem = (rem << 2) | ((v >> (2 * p)) & 128'd3);
      cand = (root << 2) | 128'd1;
      if (rem >= cand) begin
        rem = rem - cand;
        root = (root << 1) | 128'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[63:0];
  endfunction

  function automatic longint ratio(longint num, longint unsigned s);
    longint unsigned mag, q;
    mag = (num < 0) ? longint'(-num) : num;
    q = (mag << FB) / s;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [DW-1:0] clamp(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[DW-1:0];
  endfunction

  function automatic quat_t predict_quat(logic signed [DW-1:0] m[9]);
    longint a11, a12, a13, a21, a22, a23, a31, a32, a33, tr, arg, w, x, y, z;
    longint unsigned s;
    quat_t r;
    a11 = m[0]; a12 = m[1]; a13 = m[2];
    a21 = m[3]; a22 = m[4]; a23 = m[5];
    a31 = m[6]; a32 = m[7]; a33 = m[8];
    tr = a11 + a22 + a33;
    r = '0;
    if (tr > 0) begin
      r.branch = BR_TRACE;
      arg = ONE + tr;
    end else if (a11 > a22 && a11 > a33) begin
      r.branch = BR_X;
      arg = ONE + a11 - a22 - a33;
    end else if (a22 > a33) begin
      r.branch = BR_Y;
      arg = ONE + a22 - a11 - a33;
    end else begin
      r.branch = BR_Z;
      arg = ONE + a33 - a11 - a22;
    end
    if (arg <= 0) begin
      r.degen = 1'b1;
      return r;
    end
    s = scale_root(arg);
    case (r.branch)
      BR_TRACE: begin
        w = s >> 2; x = ratio(a32 - a23, s); y = ratio(a13 - a31, s); z = ratio(a21 - a12, s);
      end
      BR_X: begin
        w = ratio(a32 - a23, s); x = s >> 2; y = ratio(a12 + a21, s); z = ratio(a13 + a31, s);
      end
      BR_Y: begin
        w = ratio(a13 - a31, s); x = ratio(a12 + a21, s); y = s >> 2; z = ratio(a23 + a32, s);
      end
      default: begin
        w = ratio(a21 - a12, s); x = ratio(a13 + a31, s); y = ratio(a23 + a32, s); z = s >> 2;
      end
    endcase
    r.qw = clamp(w);
    r.qx = clamp(x);
    r.qy = clamp(y);
    r.qz = clamp(z);
    return r;
  endfunction

  // valid stays high into the next request when there is no idle gap
  task automatic send_matrix(logic signed [DW-1:0] m[9]);
    logic [143:0] d;
    int gap;
    gap = $urandom_range(0, 8);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    for (int i = 0; i < 9; i++) d[i*DW +: DW] = m[i];
    s_tdata <= d;
    s_tvalid <= 1'b1;
    quat_q.push_back(predict_quat(m));
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // receiver: random stall per result, compare with oldest prediction
  initial begin
    quat_t exp_q, got;
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = $urandom_range(0, 8);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48],
             m_tuser[1:0], m_tuser[2]};
      if (quat_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        exp_q = quat_q.pop_front();
        checked++;
        if (exp_q.degen) degen_seen++;
        branch_seen[exp_q.branch]++;
        if (got.qw !== exp_q.qw) begin
          $error("qw expected %h got %h", exp_q.qw, got.qw); errors++;
        end
        if (got.qx !== exp_q.qx) begin
          $error("qx expected %h got %h", exp_q.qx, got.qx); errors++;
        end
        if (got.qy !== exp_q.qy) begin
          $error("qy expected %h got %h", exp_q.qy, got.qy); errors++;
        end
        if (got.qz !== exp_q.qz) begin
          $error("qz expected %h got %h", exp_q.qz, got.qz); errors++;
        end
        if (got.branch !== exp_q.branch) begin
          $error("branch_taken expected %0d got %0d", exp_q.branch, got.branch); errors++;
        end
        if (got.degen !== exp_q.degen) begin
          $error("degenerate expected %0d got %0d", exp_q.degen, got.degen); errors++;
        end
      end
    end
  end

  task automatic test_corners();
    logic signed [DW-1:0] m[9];
    // identity, and the three half-turns (x, y, z largest)
    m = '{16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0, 16'sd16384}; send_matrix(m);
    m = '{16'sd16384, 0, 0, 0, -16'sd16384, 0, 0, 0, -16'sd16384}; send_matrix(m);
    m = '{-16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0, -16'sd16384}; send_matrix(m);
    m = '{-16'sd16384, 0, 0, 0, -16'sd16384, 0, 0, 0, 16'sd16384}; send_matrix(m);
    // diagonal ties go to the later branch
    m = '{-16'sd100, 5, 6, 7, -16'sd100, 8, 9, 10, -16'sd200}; send_matrix(m);
    m = '{-16'sd100, 5, 6, 7, -16'sd300, 8, 9, 10, -16'sd100}; send_matrix(m);
    m = '{-16'sd50, 5, 6, 7, -16'sd50, 8, 9, 10, -16'sd50}; send_matrix(m);
    // trace exactly zero takes the diagonal test
    m = '{16'sd100, 1, 2, 3, -16'sd50, 4, 5, 6, -16'sd50}; send_matrix(m);
    // large diagonal entries (z, trace and z branches)
    m = '{-16'sd32768, 0, 0, 0, -16'sd32768, 0, 0, 0, -16'sd32768}; send_matrix(m);
    m = '{-16'sd20000, 0, 0, 0, 16'sd20000, 0, 0, 0, 16'sd20000}; send_matrix(m);
    m = '{16'sd0, 0, 0, 0, -16'sd20000, 0, 0, 0, 16'sd20000}; send_matrix(m);
    // all field extremes
    m = '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
          16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767}; send_matrix(m);
    m = '{16'sd1, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd0,
          -16'sd32768, -16'sd32768, 16'sd32767, -16'sd1}; send_matrix(m);
    m = '{-16'sd16000, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd16000,
          16'sd32767, -16'sd32768, 16'sd32767, 16'sd16383}; send_matrix(m);
    m = '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
          -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32767}; send_matrix(m);
  endtask

  // rotation matrix from a random unit quaternion
  task automatic test_rotations(int n);
    logic signed [DW-1:0] m[9];
    real a, b, c, d, nrm;
    for (int k = 0; k < n; k++) begin
      a = $urandom_range(0, 2000) - 1000.0; b = $urandom_range(0, 2000) - 1000.0;
      c = $urandom_range(0, 2000) - 1000.0; d = $urandom_range(0, 2000) - 1000.0;
      nrm = $sqrt(a*a + b*b + c*c + d*d) + 1e-9;
      a /= nrm; b /= nrm; c /= nrm; d /= nrm;
      m[0] = $rtoi(ONE * (1 - 2*(c*c + d*d))); m[1] = $rtoi(ONE * 2*(b*c - a*d));
      m[2] = $rtoi(ONE * 2*(b*d + a*c));       m[3] = $rtoi(ONE * 2*(b*c + a*d));
      m[4] = $rtoi(ONE * (1 - 2*(b*b + d*d))); m[5] = $rtoi(ONE * 2*(c*d - a*b));
      m[6] = $rtoi(ONE * 2*(b*d - a*c));       m[7] = $rtoi(ONE * 2*(c*d + a*b));
      m[8] = $rtoi(ONE * (1 - 2*(b*b + c*c)));
      send_matrix(m);
    end
  endtask

  task automatic test_raw(int n);
    logic signed [DW-1:0] m[9];
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 9; i++) m[i] = DW'($urandom());
      send_matrix(m);
    end
  endtask

  initial begin
    int waited;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corners();
    test_rotations(500);
    test_raw(200);
    s_tvalid <= 1'b0;
    waited = 0;
    while (quat_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN) @(posedge clk);
    $display("%0d matrices sent, %0d quaternions checked (%0d degenerate)",
             sent, checked, degen_seen);
    $display("branches: trace %0d, x %0d, y %0d, z %0d",
             branch_seen[0], branch_seen[1], branch_seen[2], branch_seen[3]);
    if (errors == 0 && quat_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
